// ===== hw/rtl/tpud_pkg.sv =====
// Shared types and constants for the texture pixel unpack and detile block.
`default_nettype none
package tpud_pkg;

  localparam int RAW_W      = 32;
  localparam int ARGB_W     = 32;
  localparam int IDX_W      = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam int FMT_W      = 3;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGBA8888 = 3'd0,
    FMT_RGBA4444 = 3'd1,
    FMT_RGBA5551 = 3'd2,
    FMT_RGB565   = 3'd3,
    FMT_LA88     = 3'd4,
    FMT_L8       = 3'd5
  } pix_fmt_e;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILED_LAYOUT = 4'd3;

  localparam logic [FMT_W-1:0]      FMT_RESET    = 3'd0;
  localparam logic [CFG_DATA_W-1:0] DIM_RESET    = 13'd1;

endpackage
`default_nettype wire

// ===== hw/rtl/tpud_in_if.sv =====
// Input channel carrying one raw texel per beat.
`default_nettype none
interface tpud_in_if;
  import tpud_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_texel;
  logic             frame_start;
  modport source (output valid, output raw_texel, output frame_start, input ready);
  modport sink   (input valid, input raw_texel, input frame_start, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tpud_out_if.sv =====
// Output channel carrying one expanded pixel and its destination index per beat.
`default_nettype none
interface tpud_out_if;
  import tpud_pkg::*;
  logic              valid;
  logic              ready;
  logic [ARGB_W-1:0] argb_pixel;
  logic [IDX_W-1:0]  dest_index;
  logic              last_pixel;
  modport source (output valid, output argb_pixel, output dest_index, output last_pixel,
                  input ready);
  modport sink   (input valid, input argb_pixel, input dest_index, input last_pixel,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tpud_cfg_if.sv =====
// Configuration write channel: register index and write data per beat.
`default_nettype none
interface tpud_cfg_if;
  import tpud_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/texture_pixel_unpack_detile.sv =====
// Top level of the texture pixel unpack and detile block.
// Pipeline: a texel is registered in the input stage, then its expanded pixel in the
// result register, from which the output channel offers it.
// One texel per cycle unless the output stalls; walk counter updates are combinational.
// A stalled output still lets one further texel enter the input stage.
// Reset: registers return to rgba8888, 1x1, linear layout; walk and pipeline cleared.
`default_nettype none
module texture_pixel_unpack_detile #(
  parameter int TILE_SIZE     = 32,
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tpud_cfg_if.sink   cfg_i,
  tpud_in_if.sink    texel_i,
  tpud_out_if.source pixel_o
);
  import tpud_pkg::*;

  localparam int TBW = $clog2(TILE_SIZE);
  localparam int TCN = (MAX_DIMENSION + TILE_SIZE - 1) / TILE_SIZE;
  localparam int TCW = (TCN > 1) ? $clog2(TCN) : 1;
  localparam int XW  = TCW + TBW;
  localparam int DW  = $clog2(MAX_DIMENSION + 1);
  localparam int TW  = 2 * DW;
  localparam int SW  = (XW + DW + 1 > IDX_W) ? XW + DW + 1 : IDX_W;

  function automatic logic [DW-1:0] clamp_dim(logic [CFG_DATA_W-1:0] d);
    if (d == '0) return DW'(1);
    if (32'(d) > 32'(MAX_DIMENSION)) return DW'(MAX_DIMENSION);
    return DW'(d);
  endfunction

  // Configuration registers; the pixel total follows every size write at once.
  logic [FMT_W-1:0]      fmt_q;
  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic                  tiled_q;
  logic [TW-1:0]         total_q;
  logic [DW-1:0]         w_cl, h_cl;
  logic                  cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign w_cl        = clamp_dim(width_q);
  assign h_cl        = clamp_dim(height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_RESET;
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
      tiled_q  <= 1'b0;
      total_q  <= TW'(1);
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        REG_PIXEL_FORMAT: fmt_q <= cfg_i.data[FMT_W-1:0];
        REG_IMAGE_WIDTH: begin
          width_q <= cfg_i.data;
          total_q <= TW'(clamp_dim(cfg_i.data)) * TW'(h_cl);
        end
        REG_IMAGE_HEIGHT: begin
          height_q <= cfg_i.data;
          total_q  <= TW'(w_cl) * TW'(clamp_dim(cfg_i.data));
        end
        REG_TILED_LAYOUT: tiled_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Handshake across the two stages.
  logic s1_valid_q, out_valid_q, o_free, s1_adv, in_fire;

  assign o_free        = !out_valid_q || pixel_o.ready;
  assign s1_adv        = s1_valid_q && o_free;
  assign texel_i.ready = !s1_valid_q || o_free;
  assign in_fire       = texel_i.valid && texel_i.ready;

  // Walk counters step once per accepted beat.
  logic [XW-1:0]    w_x, w_y;
  logic [IDX_W-1:0] w_count;
  logic             w_last;

  tpud_walk #(
    .TILE_SIZE     (TILE_SIZE),
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_fire),
    .frame_start_i (texel_i.frame_start),
    .w_i           (w_cl),
    .h_i           (h_cl),
    .total_i       (total_q),
    .x_o           (w_x),
    .y_o           (w_y),
    .count_o       (w_count),
    .last_o        (w_last)
  );

  // Input stage register.
  logic [RAW_W-1:0] s1_raw_q;
  logic [XW-1:0]    s1_x_q, s1_y_q;
  logic [IDX_W-1:0] s1_count_q;
  logic             s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_raw_q   <= texel_i.raw_texel;
      s1_x_q     <= w_x;
      s1_y_q     <= w_y;
      s1_count_q <= w_count;
      s1_last_q  <= w_last;
    end
  end

  // Second stage: expansion and the row-major index.
  logic [ARGB_W-1:0] argb;
  logic [SW-1:0]     lin_full;
  logic [IDX_W-1:0]  idx;

  tpud_expand u_expand (
    .fmt_i  (fmt_q),
    .raw_i  (s1_raw_q),
    .argb_o (argb)
  );

  assign lin_full = SW'(s1_y_q) * SW'(w_cl) + SW'(s1_x_q);
  assign idx      = tiled_q ? lin_full[IDX_W-1:0] : s1_count_q;

  logic [ARGB_W-1:0] argb_q;
  logic [IDX_W-1:0]  idx_q;
  logic              last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (pixel_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      argb_q <= argb;
      idx_q  <= idx;
      last_q <= s1_last_q;
    end
  end

  assign pixel_o.valid      = out_valid_q;
  assign pixel_o.argb_pixel = argb_q;
  assign pixel_o.dest_index = idx_q;
  assign pixel_o.last_pixel = last_q;

  // A beat held in the input stage behind a stalled output must not be lost.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !o_free |=> s1_valid_q && $stable(s1_count_q) && $stable(s1_last_q))
    else $error("input stage beat lost while output stalled");

  // A frame start always presents the origin of the walk.
  a_frame_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && texel_i.frame_start |-> w_x == '0 && w_y == '0 && w_count == '0)
    else $error("frame start did not restart the walk");

  // The pixel total is never zero, so every image has a last pixel.
  a_total_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q != '0)
    else $error("pixel total is zero");

  // A last pixel leaves the walk at the first pixel for the next beat.
  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && w_last |=> w_count == '0)
    else $error("walk not restarted after last pixel");

endmodule
`default_nettype wire

// ===== hw/rtl/tpud_expand.sv =====
// Texel format expansion to ARGB8888.
`default_nettype none
module tpud_expand (
  input  wire logic [tpud_pkg::FMT_W-1:0]  fmt_i,
  input  wire logic [tpud_pkg::RAW_W-1:0]  raw_i,
  output logic      [tpud_pkg::ARGB_W-1:0] argb_o
);
  import tpud_pkg::*;

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] v;

  assign b0 = raw_i[7:0];
  assign b1 = raw_i[15:8];
  assign b2 = raw_i[23:16];
  assign b3 = raw_i[31:24];
  assign v  = raw_i[15:0];

  // A nibble times 17 is the nibble repeated; a channel times 8 or 4 is a
  // left shift with zero fill.
  always_comb begin
    case (pix_fmt_e'(fmt_i))
      FMT_RGBA4444: argb_o = {v[3:0], v[3:0], v[15:12], v[15:12],
                              v[11:8], v[11:8], v[7:4], v[7:4]};
      FMT_RGBA5551: argb_o = {{8{v[0]}}, v[15:11], 3'b000, v[10:6], 3'b000,
                              v[5:1], 3'b000};
      FMT_RGB565:   argb_o = {8'hFF, v[15:11], 3'b000, v[10:5], 2'b00, v[4:0], 3'b000};
      FMT_LA88:     argb_o = {b1, b0, b0, b0};
      FMT_L8:       argb_o = {8'hFF, b0, b0, b0};
      default:      argb_o = {b3, b0, b1, b2};
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tpud_walk.sv =====
// Pixel walk counters: tile position, position within tile and pixel count.
`default_nettype none
module tpud_walk #(
  parameter int TILE_SIZE     = 32,
  parameter int MAX_DIMENSION = 4096,
  localparam int TBW = $clog2(TILE_SIZE),
  localparam int TCN = (MAX_DIMENSION + TILE_SIZE - 1) / TILE_SIZE,
  localparam int TCW = (TCN > 1) ? $clog2(TCN) : 1,
  localparam int XW  = TCW + TBW,
  localparam int DW  = $clog2(MAX_DIMENSION + 1),
  localparam int TW  = 2 * DW
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic                         frame_start_i,
  input  wire logic [DW-1:0]                w_i,
  input  wire logic [DW-1:0]                h_i,
  input  wire logic [TW-1:0]                total_i,
  output logic      [XW-1:0]                x_o,
  output logic      [XW-1:0]                y_o,
  output logic      [tpud_pkg::IDX_W-1:0]   count_o,
  output logic                              last_o
);
  import tpud_pkg::*;

  localparam int CW = (TW > IDX_W) ? TW + 1 : IDX_W + 1;

  logic [TCW-1:0]   tc_q, tc_d, tr_q, tr_d, tc_e, tr_e;
  logic [TBW-1:0]   cw_q, cw_d, rw_q, rw_d, cw_e, rw_e;
  logic [IDX_W-1:0] pc_q, pc_d, pc_e;

  function automatic int unsigned tile_extent(logic [TCW-1:0] tile, logic [DW-1:0] dim);
    int unsigned base;
    int unsigned rest;
    base = 32'(tile) * 32'(TILE_SIZE);
    if (base >= 32'(dim)) return 0;
    rest = 32'(dim) - base;
    return (rest < 32'(TILE_SIZE)) ? rest : 32'(TILE_SIZE);
  endfunction

  // A frame start makes this beat the first pixel of the walk.
  assign tc_e = frame_start_i ? '0 : tc_q;
  assign tr_e = frame_start_i ? '0 : tr_q;
  assign cw_e = frame_start_i ? '0 : cw_q;
  assign rw_e = frame_start_i ? '0 : rw_q;
  assign pc_e = frame_start_i ? '0 : pc_q;

  assign x_o     = XW'(XW'(tc_e) * XW'(TILE_SIZE)) + XW'(cw_e);
  assign y_o     = XW'(XW'(tr_e) * XW'(TILE_SIZE)) + XW'(rw_e);
  assign count_o = pc_e;
  assign last_o  = (CW'(pc_e) + CW'(1)) >= CW'(total_i);

  // Each counter wraps to zero at its carry, so stale values left by a size
  // change fall back into range.
  always_comb begin
    tc_d = tc_e;
    tr_d = tr_e;
    cw_d = cw_e;
    rw_d = rw_e;
    pc_d = pc_e + IDX_W'(1);
    if (last_o) begin
      tc_d = '0;
      tr_d = '0;
      cw_d = '0;
      rw_d = '0;
      pc_d = '0;
    end else if (32'(cw_e) + 32'd1 < tile_extent(tc_e, w_i)) begin
      cw_d = cw_e + TBW'(1);
    end else begin
      cw_d = '0;
      if (32'(rw_e) + 32'd1 < tile_extent(tr_e, h_i)) begin
        rw_d = rw_e + TBW'(1);
      end else begin
        rw_d = '0;
        if ((32'(tc_e) + 32'd1) * 32'(TILE_SIZE) < 32'(w_i)) begin
          tc_d = tc_e + TCW'(1);
        end else begin
          tc_d = '0;
          if ((32'(tr_e) + 32'd1) * 32'(TILE_SIZE) < 32'(h_i)) begin
            tr_d = tr_e + TCW'(1);
          end else begin
            tr_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      tr_q <= '0;
      cw_q <= '0;
      rw_q <= '0;
      pc_q <= '0;
    end else if (step_i) begin
      tc_q <= tc_d;
      tr_q <= tr_d;
      cw_q <= cw_d;
      rw_q <= rw_d;
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_texture_pixel_unpack_detile.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for texture_pixel_unpack_detile: texel streams against a predictor.
module tb_texture_pixel_unpack_detile;
  import tpud_pkg::*;

  localparam int TILE        = 32;
  localparam int MAX_DIM     = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 2000;
  localparam int IDLE_PCT    = 11;
  localparam int RANDOM_BEATS = 500;
  localparam int MAX_REPORTS = 25;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 4'd15;
  localparam logic [FMT_W-1:0]     FMT_SPARE_HI    = 3'd7;

  typedef struct packed {
    logic [ARGB_W-1:0] argb;
    logic [IDX_W-1:0]  dest;
    logic              last;
  } pixel_t;

  class pixel_scoreboard;
    logic [FMT_W-1:0]      fmt;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic                  tiled;
    logic [6:0]            tile_col;
    logic [6:0]            tile_row;
    logic [4:0]            row_in;
    logic [4:0]            col_in;
    logic [IDX_W-1:0]      count;
    pixel_t                pending_q[$];
    int                    errors;
    int                    checked;
    int                    frames_ended;

    function new();
      errors = 0;
      checked = 0;
      frames_ended = 0;
      fmt = FMT_RESET;
      width_reg = DIM_RESET;
      height_reg = DIM_RESET;
      tiled = 1'b0;
      clear_walk();
    endfunction

    function void clear_walk();
      tile_col = '0;
      tile_row = '0;
      row_in = '0;
      col_in = '0;
      count = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PIXEL_FORMAT: fmt = data[FMT_W-1:0];
        REG_IMAGE_WIDTH:  width_reg = data;
        REG_IMAGE_HEIGHT: height_reg = data;
        REG_TILED_LAYOUT: tiled = data[0];
        default: ;
      endcase
    endfunction

    function int clamp_dim(logic [CFG_DATA_W-1:0] d);
      if (d == '0) return 1;
      if (int'(d) > MAX_DIM) return MAX_DIM;
      return int'(d);
    endfunction

    // Pixels of a tile along one axis; edge tiles are short, tiles past the edge empty.
    function int span(int tile, int dim);
      int base;
      base = tile * TILE;
      if (base >= dim) return 0;
      return (dim - base < TILE) ? dim - base : TILE;
    endfunction

    function logic [ARGB_W-1:0] expand(logic [FMT_W-1:0] f, logic [RAW_W-1:0] raw);
      logic [15:0] v;
      logic [7:0]  a, r, g, b;
      v = raw[15:0];
      case (f)
        FMT_RGBA4444: begin
          a = 8'(int'(v[3:0]) * 17);
          r = 8'(int'(v[15:12]) * 17);
          g = 8'(int'(v[11:8]) * 17);
          b = 8'(int'(v[7:4]) * 17);
        end
        FMT_RGBA5551: begin
          a = v[0] ? 8'hFF : 8'h00;
          r = {v[15:11], 3'b000};
          g = {v[10:6], 3'b000};
          b = {v[5:1], 3'b000};
        end
        FMT_RGB565: begin
          a = 8'hFF;
          r = {v[15:11], 3'b000};
          g = {v[10:5], 2'b00};
          b = {v[4:0], 3'b000};
        end
        FMT_LA88: begin
          a = raw[15:8];
          r = raw[7:0];
          g = raw[7:0];
          b = raw[7:0];
        end
        FMT_L8: begin
          a = 8'hFF;
          r = raw[7:0];
          g = raw[7:0];
          b = raw[7:0];
        end
        default: begin
          a = raw[31:24];
          r = raw[7:0];
          g = raw[15:8];
          b = raw[23:16];
        end
      endcase
      return {a, r, g, b};
    endfunction

    // Each counter carries into the next one up and wraps to zero once it runs past its range.
    function void step_walk(int w, int h);
      if (int'(col_in) + 1 < span(int'(tile_col), w)) begin
        col_in++;
        return;
      end
      col_in = '0;
      if (int'(row_in) + 1 < span(int'(tile_row), h)) begin
        row_in++;
        return;
      end
      row_in = '0;
      if ((int'(tile_col) + 1) * TILE < w) begin
        tile_col++;
        return;
      end
      tile_col = '0;
      if ((int'(tile_row) + 1) * TILE < h) tile_row++;
      else tile_row = '0;
    endfunction

    function void note_texel(logic [RAW_W-1:0] raw, logic fs);
      int     w, h;
      longint total, x, y, dest;
      pixel_t p;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      total = longint'(w) * longint'(h);
      if (fs) clear_walk();
      if (tiled) begin
        x = longint'(tile_col) * TILE + longint'(col_in);
        y = longint'(tile_row) * TILE + longint'(row_in);
        dest = y * w + x;
      end else begin
        dest = longint'(count);
      end
      p.argb = expand(fmt, raw);
      p.dest = dest[IDX_W-1:0];
      p.last = (longint'(count) + 1 >= total);
      pending_q.push_back(p);
      if (p.last) begin
        clear_walk();
      end else begin
        count = count + IDX_W'(1);
        step_walk(w, h);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endtask

    task check_pixel(logic [ARGB_W-1:0] argb, logic [IDX_W-1:0] dest, logic last);
      pixel_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("pixel %h to %0d arrived with no texel outstanding", argb, dest));
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (argb !== e.argb)
        report($sformatf("argb_pixel %h, expected %h (beat %0d)", argb, e.argb, checked));
      if (dest !== e.dest)
        report($sformatf("dest_index %0d, expected %0d (beat %0d)", dest, e.dest, checked));
      if (last !== e.last)
        report($sformatf("last_pixel %b, expected %b (beat %0d)", last, e.last, checked));
      if (last === 1'b1) frames_ended++;
    endtask

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   texels_sent = 0;
  bit   calm = 1'b0;
  pixel_scoreboard sb;

  tpud_cfg_if cfg_bus();
  tpud_in_if  texel_bus();
  tpud_out_if pixel_bus();

  texture_pixel_unpack_detile uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_bus),
    .texel_i (texel_bus),
    .pixel_o (pixel_bus)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Output side: back-pressure at random, except during calm stretches.
  initial begin
    pixel_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      pixel_bus.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pixel_bus.valid === 1'b1 && pixel_bus.ready === 1'b1)
      sb.check_pixel(pixel_bus.argb_pixel, pixel_bus.dest_index, pixel_bus.last_pixel);
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic send_texel(input logic [RAW_W-1:0] raw, input logic fs);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      texel_bus.valid = 1'b0;
    end
    @(negedge clk);
    texel_bus.valid       = 1'b1;
    texel_bus.raw_texel   = raw;
    texel_bus.frame_start = fs;
    do @(posedge clk); while (texel_bus.ready !== 1'b1);
    sb.note_texel(raw, fs);
    texels_sent++;
  endtask

  // Hold the input back until every pixel is out, so that registers change only when idle.
  task automatic drain();
    @(negedge clk);
    texel_bus.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(MAX_DIM, 8191));
      2:       return '1;
      3:       return CFG_DATA_W'($urandom_range(TILE - 1, TILE + 2));
      default: return CFG_DATA_W'($urandom_range(1, 80));
    endcase
  endfunction

  initial begin
    int w, h, hmax, n, phase, random_sent, waited;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = '0;
    cfg_bus.data          = '0;
    texel_bus.valid       = 1'b0;
    texel_bus.raw_texel   = '0;
    texel_bus.frame_start = 1'b0;
    rst_n = 1'b0;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values first: a 1x1 linear image, so every texel is a frame end.
    send_texel('1, 1'b0);
    drain();
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      cfg_write(CFG_IDX_W'(i), '1);
    send_texel('0, 1'b0);

    // Oversized width saturates, zero height counts as one row.
    drain();
    cfg_write(REG_IMAGE_WIDTH, '1);
    cfg_write(REG_IMAGE_HEIGHT, '0);
    cfg_write(REG_TILED_LAYOUT, CFG_DATA_W'(1));
    for (int f = FMT_RGBA8888; f <= FMT_SPARE_HI; f++) begin
      drain();
      cfg_write(REG_PIXEL_FORMAT, CFG_DATA_W'(f));
      send_texel('1, 1'b0);
      send_texel('0, 1'b0);
    end

    // Shrinking the image mid-frame leaves the count past the end, so the next texel is last.
    drain();
    cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
    cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
    send_texel($urandom, 1'b0);

    drain();
    cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(MAX_DIM));
    cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(MAX_DIM));
    send_texel($urandom, 1'b1);
    send_texel($urandom, 1'b0);
    send_texel($urandom, 1'b0);
    drain();
    cfg_write(REG_TILED_LAYOUT, CFG_DATA_W'(0));
    send_texel($urandom, 1'b0);
    send_texel($urandom, 1'b1);

    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_BEATS) begin
      calm = (phase % 9 == 4);
      drain();
      if ($urandom_range(0, 9) < 7) begin
        // Whole frames of a small image, usually opened with a frame start.
        w = $urandom_range(1, TILE + 4);
        hmax = 150 / w;
        if (hmax > 40) hmax = 40;
        h = $urandom_range(1, hmax);
        cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        if ($urandom_range(0, 1)) cfg_write(REG_PIXEL_FORMAT, CFG_DATA_W'($urandom_range(0, 7)));
        if ($urandom_range(0, 1)) cfg_write(REG_TILED_LAYOUT, CFG_DATA_W'($urandom_range(0, 1)));
        n = w * h + $urandom_range(0, 3);
        for (int k = 0; k < n; k++)
          send_texel($urandom, (k == 0) && ($urandom_range(0, 4) != 0));
      end else begin
        // Noise: odd sizes, mode flips and stray frame starts in the middle of a walk.
        if ($urandom_range(0, 1)) cfg_write(REG_PIXEL_FORMAT, CFG_DATA_W'($urandom_range(0, 7)));
        if ($urandom_range(0, 1)) cfg_write(REG_IMAGE_WIDTH, pick_dim());
        if ($urandom_range(0, 1)) cfg_write(REG_IMAGE_HEIGHT, pick_dim());
        if ($urandom_range(0, 1)) cfg_write(REG_TILED_LAYOUT, CFG_DATA_W'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
          cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                    CFG_DATA_W'($urandom));
        n = $urandom_range(3, 30);
        for (int k = 0; k < n; k++)
          send_texel($urandom, $urandom_range(0, 19) == 0);
      end
      random_sent += n;
      phase++;
    end
    calm = 1'b0;

    @(negedge clk);
    texel_bus.valid = 1'b0;
    waited = 0;
    while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d pixels never arrived", sb.outstanding()));
    // Any stray beat after this point shows up as unexpected.
    repeat (8) @(posedge clk);

    $display("Sent %0d texels over %0d random phases: all format codes, linear and tiled walks.",
             texels_sent, phase);
    $display("Checked %0d pixels, %0d frame ends, %0d mismatches.",
             sb.checked, sb.frames_ended, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== texture_pixel_unpack_detile.f =====
hw/rtl/tpud_pkg.sv
hw/rtl/tpud_in_if.sv
hw/rtl/tpud_out_if.sv
hw/rtl/tpud_cfg_if.sv
hw/rtl/tpud_expand.sv
hw/rtl/tpud_walk.sv
hw/rtl/texture_pixel_unpack_detile.sv
tb/tb_texture_pixel_unpack_detile.sv
